### src/stsl_pkg.sv
// Shared types and constants for the sparse triplet store lookup core.
// Holds the word structs, status codes and the token passed along the cell chain.
// No dependencies.
package stsl_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int COORD_W = 8;
    localparam int VAL_W   = 32;
    localparam int DIM_W   = 9;
    localparam int CFG_IDX_W = 1;

    // Operation codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_COLS = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_ZERO  = 2'd1,
        STATUS_FULL  = 2'd2,
        STATUS_RANGE = 2'd3
    } t_status;

    typedef struct packed {
        logic                      func;
        logic [COORD_W-1:0]        row_index;
        logic [COORD_W-1:0]        col_index;
        logic signed [VAL_W-1:0]   elem_value;
    } t_in;

    typedef struct packed {
        logic signed [VAL_W-1:0]   read_value;
        logic                      hit;
        logic [1:0]                status;
        logic [CNT_W-1:0]          stored_count;
    } t_out;

    // One stored triplet
    typedef struct packed {
        logic [COORD_W-1:0]        row;
        logic [COORD_W-1:0]        col;
        logic signed [VAL_W-1:0]   value;
    } t_entry;

    // Lookup query moving through the chain, one cell per cycle
    typedef struct packed {
        logic                      vld;
        logic [COORD_W-1:0]        row;
        logic [COORD_W-1:0]        col;
        logic                      found;
        logic signed [VAL_W-1:0]   value;
    } t_token;

endpackage

### src/sparse_triplet_store_lookup_core.sv
// Top level of the sparse triplet store lookup core.
// Control, configuration registers and the chain of stsl_cell instances.
// Depends on stsl_pkg and stsl_cell.
//
// Usage:
//   Issue a word on i_in with i_start high while o_busy is low; it is taken
//   at that clock edge. Each word yields exactly one result word on o_out,
//   marked by o_valid for a single cycle; the receiver cannot stall it.
//   An insert, or a lookup outside matrix_rows x matrix_cols, returns its
//   result in the cycle after acceptance; the core is ready again at once.
//   An in-range lookup sends a query down the chain of ENTRIES cells, one
//   cell per cycle, and its result is registered as the query leaves the
//   tail cell; o_busy stays high during that walk. The chain length sets
//   the lookup latency; inserts write the cell chosen by the triplet count.
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
//   (0 matrix_rows, 1 matrix_cols) at the clock edge. Write it only while
//   idle; the core does not enforce it. Reset (i_rst_n low, synchronous)
//   empties the table, clears both dimensions, drops any lookup in flight.
module sparse_triplet_store_lookup_core
    import stsl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  t_in                  i_in,
    output logic                 o_valid,
    output t_out                 o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DIM_W-1:0]     i_cfg_data
);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_count;
    logic [DIM_W-1:0] r_rows;
    logic [DIM_W-1:0] r_cols;
    logic             r_valid;
    t_out             r_out;

    logic             w_accept;
    logic             w_in_range;
    logic             w_full;
    logic             w_ins_ok;
    t_entry           w_wr_entry;
    t_token           w_tok [ENTRIES+1];

    // Decode the accepted word
    assign w_accept   = i_start && (r_state == ST_IDLE);
    assign w_in_range = ({1'b0, i_in.row_index} < r_rows) &&
                        ({1'b0, i_in.col_index} < r_cols);
    assign w_full     = (r_count == CNT_W'(ENTRIES));
    assign w_ins_ok   = w_accept && (i_in.func == FUNC_INSERT) &&
                        (i_in.elem_value != '0) && !w_full;

    assign w_wr_entry.row   = i_in.row_index;
    assign w_wr_entry.col   = i_in.col_index;
    assign w_wr_entry.value = i_in.elem_value;

    // Launch the lookup query into the head of the chain
    always_comb begin
        w_tok[0].vld   = w_accept && (i_in.func == FUNC_LOOKUP) && w_in_range;
        w_tok[0].row   = i_in.row_index;
        w_tok[0].col   = i_in.col_index;
        w_tok[0].found = 1'b0;
        w_tok[0].value = '0;
    end

    // Chain of cells, one triplet each
    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        stsl_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_wr_en    (w_ins_ok && (r_count[IDX_W-1:0] == IDX_W'(k))),
            .i_wr_entry (w_wr_entry),
            .i_tok      (w_tok[k]),
            .o_tok      (w_tok[k+1])
        );
    end

    // Hold state, count, configuration and the result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_rows  <= '0;
            r_cols  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MATRIX_ROWS: r_rows <= i_cfg_data;
                    CFG_MATRIX_COLS: r_cols <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_out.read_value <= '0;
                        r_out.hit        <= 1'b0;
                        r_out.stored_count <= r_count;
                        if (i_in.func == FUNC_INSERT) begin
                            r_valid <= 1'b1;
                            if (i_in.elem_value == '0) begin
                                r_out.status <= STATUS_ZERO;
                            end else if (w_full) begin
                                r_out.status <= STATUS_FULL;
                            end else begin
                                r_out.status       <= STATUS_OK;
                                r_out.stored_count <= r_count + CNT_W'(1);
                                r_count            <= r_count + CNT_W'(1);
                            end
                        end else if (!w_in_range) begin
                            r_valid      <= 1'b1;
                            r_out.status <= STATUS_RANGE;
                        end else begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    // Emit when the query leaves the tail of the chain
                    if (w_tok[ENTRIES].vld) begin
                        r_valid            <= 1'b1;
                        r_out.read_value   <= w_tok[ENTRIES].found ?
                                              w_tok[ENTRIES].value : '0;
                        r_out.hit          <= w_tok[ENTRIES].found;
                        r_out.status       <= STATUS_OK;
                        r_out.stored_count <= r_count;
                        r_state            <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_busy  = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule

### src/stsl_cell.sv
// One cell of the triplet chain: holds a single triplet and its valid bit.
// Compares the passing lookup token and hands it to the next cell.
// Depends on stsl_pkg.
module stsl_cell
    import stsl_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr_en,
    input  t_entry i_wr_entry,
    input  t_token i_tok,
    output t_token o_tok
);

    logic   r_vld;
    t_entry r_entry;
    t_token r_tok;
    t_token n_tok;

    // Mark the cell as holding a triplet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_wr_en) begin
            r_vld <= 1'b1;
        end
    end

    // Store the triplet
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_entry <= i_wr_entry;
        end
    end

    // Capture the first match only; later cells pass it on untouched
    always_comb begin
        n_tok = i_tok;
        if (i_tok.vld && !i_tok.found && r_vld &&
            r_entry.row == i_tok.row && r_entry.col == i_tok.col) begin
            n_tok.found = 1'b1;
            n_tok.value = r_entry.value;
        end
    end

    // Advance the token one cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

### dv/stsl_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the sparse triplet store lookup core: watches the command,
// result and register ports, predicts each result word and compares it.
// Depends on stsl_pkg.
module stsl_checker
    import stsl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  t_in                  i_in,
    input  logic                 i_valid,
    input  t_out                 i_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DIM_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    // dimensions above this count as this
    localparam int DIM_CAP = 256;

    t_entry           triplet_mem [ENTRIES];
    int               held_count;
    logic [DIM_W-1:0] dim_rows;
    logic [DIM_W-1:0] dim_cols;
    t_out             expected_words [$];
    int               mismatch_count;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        held_count   = 0;
        dim_rows     = '0;
        dim_cols     = '0;
        mismatch_count = 0;
    end

    // Work out the result of one word and update the table copy
    function automatic t_out triplet_predict(t_in w);
        t_out             res;
        logic [DIM_W-1:0] lim_r;
        logic [DIM_W-1:0] lim_c;
        int               k;
        res = '0;
        if (w.func == FUNC_INSERT) begin
            if (w.elem_value == 0) begin
                res.status = STATUS_ZERO;
            end else if (held_count >= ENTRIES) begin
                res.status = STATUS_FULL;
            end else begin
                triplet_mem[held_count].row   = w.row_index;
                triplet_mem[held_count].col   = w.col_index;
                triplet_mem[held_count].value = w.elem_value;
                held_count++;
            end
        end else begin
            lim_r = (dim_rows > DIM_CAP) ? DIM_W'(DIM_CAP) : dim_rows;
            lim_c = (dim_cols > DIM_CAP) ? DIM_W'(DIM_CAP) : dim_cols;
            if ({1'b0, w.row_index} >= lim_r || {1'b0, w.col_index} >= lim_c) begin
                res.status = STATUS_RANGE;
            end else begin
                // earliest stored triplet wins on duplicate coordinates
                for (k = 0; k < held_count && !res.hit; k++) begin
                    if (triplet_mem[k].row == w.row_index &&
                        triplet_mem[k].col == w.col_index) begin
                        res.read_value = triplet_mem[k].value;
                        res.hit        = 1'b1;
                    end
                end
            end
        end
        res.stored_count = CNT_W'(held_count);
        return res;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Pop results first, then push the prediction for a word taken at this edge
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            held_count = 0;
            dim_rows   = '0;
            dim_cols   = '0;
            expected_words.delete();
        end else begin
            if (i_valid) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: result word with none expected, actual %0h",
                             $time, i_out);
                    mismatch_count++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("read_value", want.read_value, i_out.read_value);
                    check_field("hit", want.hit, i_out.hit);
                    check_field("status", want.status, i_out.status);
                    check_field("stored_count", want.stored_count, i_out.stored_count);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MATRIX_ROWS: dim_rows = i_cfg_data;
                    CFG_MATRIX_COLS: dim_cols = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                expected_words.push_back(triplet_predict(i_in));
            end
        end
        o_fail_count <= mismatch_count;
        o_pending    <= expected_words.size();
    end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// Top of the sparse triplet store lookup testbench: clock, reset, command
// and register stimulus, and the verdict. Depends on stsl_pkg, stsl_checker
// and sparse_triplet_store_lookup_core.
module tb_top;
    import stsl_pkg::*;

    localparam int PHASES     = 6;
    localparam int PHASE_LEN  = 290;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_start = 1'b0;
    logic                 o_busy;
    t_in                  i_in = '0;
    logic                 o_valid;
    t_out                 o_out;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [DIM_W-1:0]     i_cfg_data = '0;
    int                   fail_count;
    int                   pending;

    // dimension settings per random phase, extremes included
    int rows_plan [PHASES] = '{16, 256, 511, 0, 200, 12};
    int cols_plan [PHASES] = '{16, 256, 300, 511, 9, 255};

    logic [COORD_W-1:0] placed_rows [$];
    logic [COORD_W-1:0] placed_cols [$];
    int                 stored_guess = 0;

    always #6 i_clk = ~i_clk;

    sparse_triplet_store_lookup_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    stsl_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_busy       (o_busy),
        .i_in         (i_in),
        .i_valid      (o_valid),
        .i_out        (o_out),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic t_in make_word(logic f, logic [7:0] r, logic [7:0] c,
                                      logic [31:0] v);
        t_in w;
        w.func       = f;
        w.row_index  = r;
        w.col_index  = c;
        w.elem_value = v;
        return w;
    endfunction

    // Hold the word with start high until the core takes it
    task automatic issue_word(t_in w);
        i_in    <= w;
        i_start <= 1'b1;
        do @(posedge i_clk); while (o_busy);
    endtask

    // Drop start for a random number of cycles
    task automatic sender_idle(int pct);
        while ($urandom_range(99) < pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Hold off until every expected result word has come back
    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_dims(int rows, int cols);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MATRIX_ROWS;
        i_cfg_data <= DIM_W'(rows);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MATRIX_COLS;
        i_cfg_data <= DIM_W'(cols);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Fill the table from a mix of small and wide coordinates, then mostly
    // look up coordinates already placed so lookups hit deep in the chain
    function automatic t_in random_word();
        int          sel;
        int          pick;
        logic [7:0]  r;
        logic [7:0]  c;
        logic [31:0] v;
        sel = $urandom_range(99);
        if (sel < ((stored_guess < ENTRIES) ? 55 : 12)) begin
            if ($urandom_range(1) == 0) begin
                r = 8'($urandom_range(15));
                c = 8'($urandom_range(15));
            end else begin
                r = 8'($urandom);
                c = 8'($urandom);
            end
            pick = $urandom_range(99);
            if (pick < 8) begin
                v = '0;
            end else if (pick < 12) begin
                v = ($urandom_range(1) == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                v = $urandom;
                if (v == 0) v = 32'h1;
            end
            if (v != 0) begin
                stored_guess++;
                if (placed_rows.size() < ENTRIES) begin
                    placed_rows.push_back(r);
                    placed_cols.push_back(c);
                end
            end
            return make_word(FUNC_INSERT, r, c, v);
        end
        pick = $urandom_range(99);
        if (pick < 60 && placed_rows.size() != 0) begin
            sel = $urandom_range(placed_rows.size() - 1);
            r   = placed_rows[sel];
            c   = placed_cols[sel];
        end else if (pick < 85) begin
            r = 8'($urandom_range(15));
            c = 8'($urandom_range(15));
        end else begin
            r = 8'($urandom);
            c = 8'($urandom);
        end
        return make_word(FUNC_LOOKUP, r, c, $urandom);
    endfunction

    // Overall run limit
    initial begin
        #12_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int p;
        int n;
        int idle_pct;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // dimensions still zero after reset: every lookup is out of range
        issue_word(make_word(FUNC_LOOKUP, 8'd0, 8'd0, 32'd0));
        drain();
        write_dims(256, 256);

        // extremes, zero value, duplicate coordinates, miss on empty table
        issue_word(make_word(FUNC_INSERT, 8'd0, 8'd0, 32'd0));
        issue_word(make_word(FUNC_LOOKUP, 8'd0, 8'd0, 32'hFFFF_FFFF));
        issue_word(make_word(FUNC_INSERT, 8'd0, 8'd0, 32'h8000_0000));
        issue_word(make_word(FUNC_INSERT, 8'd255, 8'd255, 32'h7FFF_FFFF));
        issue_word(make_word(FUNC_INSERT, 8'd0, 8'd0, 32'hFFFF_FFFF));
        issue_word(make_word(FUNC_INSERT, 8'd255, 8'd0, 32'h0000_0001));
        issue_word(make_word(FUNC_INSERT, 8'd0, 8'd255, 32'hAAAA_AAAA));
        issue_word(make_word(FUNC_LOOKUP, 8'd0, 8'd0, 32'd0));
        issue_word(make_word(FUNC_LOOKUP, 8'd255, 8'd255, 32'd0));
        issue_word(make_word(FUNC_LOOKUP, 8'd255, 8'd0, 32'h5555_5555));
        issue_word(make_word(FUNC_LOOKUP, 8'd0, 8'd255, 32'd0));
        issue_word(make_word(FUNC_LOOKUP, 8'd0, 8'd1, 32'd0));
        issue_word(make_word(FUNC_LOOKUP, 8'd128, 8'd128, 32'hFFFF_FFFF));
        issue_word(make_word(FUNC_INSERT, 8'd255, 8'd255, 32'd0));
        stored_guess = 5;

        // tight dimensions: last row and column fall just outside
        drain();
        write_dims(255, 1);
        issue_word(make_word(FUNC_LOOKUP, 8'd254, 8'd0, 32'd0));
        issue_word(make_word(FUNC_LOOKUP, 8'd255, 8'd0, 32'd0));
        issue_word(make_word(FUNC_LOOKUP, 8'd0, 8'd1, 32'd0));
        issue_word(make_word(FUNC_LOOKUP, 8'd0, 8'd0, 32'd0));

        // random phases, each under its own dimensions and sender pacing
        for (p = 0; p < PHASES; p++) begin
            drain();
            write_dims(rows_plan[p], cols_plan[p]);
            idle_pct = (p < 2) ? 10 : ((p < 4) ? 84 : 0);
            for (n = 0; n < PHASE_LEN; n++) begin
                sender_idle(idle_pct);
                issue_word(random_word());
            end
        end

        // wait out the last results, bounded
        i_start <= 1'b0;
        for (n = 0; n < 2000 && pending != 0; n++) @(posedge i_clk);
        repeat (70) @(posedge i_clk);
        if (pending != 0) begin
            $display("%0t: %0d result words never arrived", $time, pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
